// ----- src/vsrt_pkg.sv -----
// ----------------------------------------------------------------------------
// vsrt_pkg
// Shared types, constants and fixed-point helpers for the vertex transform.
// ----------------------------------------------------------------------------
package vsrt_pkg;

    localparam int COORD_W = 32;
    localparam int ANGLE_W = 16;
    localparam int TABLE_W = 17;   // table entries, 0 .. 65536
    localparam int TRIG_W  = 18;   // signed sine or cosine, Q1.16

    localparam int DEFAULT_SINE_TABLE_DEPTH = 1024;

    // pi/2 in Q2.30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Taylor series divisors (2n)(2n+1) for n = 1 .. 10
    localparam longint unsigned TAYLOR_DIV [1:10] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
          64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [TRIG_W-1:0]  trig_val_t;
    typedef logic [ANGLE_W-1:0]        angle_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec3_t;

    typedef struct packed {
        trig_val_t sin_x;
        trig_val_t cos_x;
        trig_val_t sin_y;
        trig_val_t cos_y;
        trig_val_t sin_z;
        trig_val_t cos_z;
    } trig_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic coord_t sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return coord_t'(32'h7FFF_FFFF);
        end else if (v < -64'sd2147483648) begin
            return coord_t'(32'h8000_0000);
        end
        return coord_t'(v[COORD_W-1:0]);
    endfunction

    // Round half up from Q32.32 to Q16.16, then saturate.
    function automatic coord_t round_q16(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd32768) >>> 16;
        return sat32(t);
    endfunction

endpackage

// ----- src/vsrt_ram.sv -----
// ----------------------------------------------------------------------------
// vsrt_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module vsrt_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1025
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- src/vsrt_sincos.sv -----
// ----------------------------------------------------------------------------
// vsrt_sincos
// Quarter-wave table lookup giving sine and cosine of one angle.
// ----------------------------------------------------------------------------
module vsrt_sincos #(
    parameter int SINE_TABLE_DEPTH = vsrt_pkg::DEFAULT_SINE_TABLE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                en,
    input  logic                                fill_we,
    input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] fill_addr,
    input  logic [vsrt_pkg::TABLE_W-1:0]        fill_data,
    input  vsrt_pkg::angle_t                    angle,
    output vsrt_pkg::trig_val_t                 sin_val,
    output vsrt_pkg::trig_val_t                 cos_val
);

    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_W = 14 + ADDR_W;

    vsrt_pkg::angle_t          cos_angle;
    logic [PROD_W-1:0]         sin_prod;
    logic [PROD_W-1:0]         cos_prod;
    logic [ADDR_W-1:0]         sin_idx;
    logic [ADDR_W-1:0]         cos_idx;
    logic [ADDR_W-1:0]         sin_addr;
    logic [ADDR_W-1:0]         cos_addr;
    logic [vsrt_pkg::TABLE_W-1:0] sin_mag;
    logic [vsrt_pkg::TABLE_W-1:0] cos_mag;
    logic                      sin_neg_reg;
    logic                      cos_neg_reg;

    assign cos_angle = angle + vsrt_pkg::angle_t'(16'h4000);

    // Table index is the in-quadrant offset scaled down to the table depth.
    assign sin_prod = PROD_W'(angle[13:0]) * PROD_W'(SINE_TABLE_DEPTH);
    assign cos_prod = PROD_W'(cos_angle[13:0]) * PROD_W'(SINE_TABLE_DEPTH);
    assign sin_idx  = sin_prod[PROD_W-1:14];
    assign cos_idx  = cos_prod[PROD_W-1:14];

    // Odd quadrants walk the table backwards.
    assign sin_addr = angle[14] ? ADDR_W'(SINE_TABLE_DEPTH) - sin_idx : sin_idx;
    assign cos_addr = cos_angle[14] ? ADDR_W'(SINE_TABLE_DEPTH) - cos_idx : cos_idx;

    vsrt_ram #(
        .WIDTH (vsrt_pkg::TABLE_W),
        .DEPTH (SINE_TABLE_DEPTH + 1)
    ) u_table (
        .aclk    (aclk),
        .we      (fill_we),
        .waddr   (fill_addr),
        .wdata   (fill_data),
        .re      (en),
        .raddr_a (sin_addr),
        .raddr_b (cos_addr),
        .rdata_a (sin_mag),
        .rdata_b (cos_mag)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_neg_reg <= angle[15];
            cos_neg_reg <= cos_angle[15];
        end
    end

    assign sin_val = sin_neg_reg ? -vsrt_pkg::trig_val_t'(sin_mag)
                                 :  vsrt_pkg::trig_val_t'(sin_mag);
    assign cos_val = cos_neg_reg ? -vsrt_pkg::trig_val_t'(cos_mag)
                                 :  vsrt_pkg::trig_val_t'(cos_mag);

endmodule

// ----- src/vsrt_rotate.sv -----
// ----------------------------------------------------------------------------
// vsrt_rotate
// Two-stage plane rotation: products, then difference, sum and rounding.
// ----------------------------------------------------------------------------
module vsrt_rotate (
    input  logic                aclk,
    input  logic                en_prod,
    input  logic                en_round,
    input  vsrt_pkg::coord_t    a_in,
    input  vsrt_pkg::coord_t    b_in,
    input  vsrt_pkg::coord_t    pass_in,
    input  vsrt_pkg::trig_val_t cos_in,
    input  vsrt_pkg::trig_val_t sin_in,
    output vsrt_pkg::coord_t    a_out,
    output vsrt_pkg::coord_t    b_out,
    output vsrt_pkg::coord_t    pass_out
);

    localparam int PROD_W = vsrt_pkg::COORD_W + vsrt_pkg::TRIG_W;

    logic signed [PROD_W-1:0] ac_reg;
    logic signed [PROD_W-1:0] bs_reg;
    logic signed [PROD_W-1:0] as_reg;
    logic signed [PROD_W-1:0] bc_reg;
    vsrt_pkg::coord_t         pass_a_reg;
    vsrt_pkg::coord_t         a_reg;
    vsrt_pkg::coord_t         b_reg;
    vsrt_pkg::coord_t         pass_b_reg;
    logic signed [PROD_W:0]   diff;
    logic signed [PROD_W:0]   sum;

    always_ff @(posedge aclk) begin
        if (en_prod) begin
            ac_reg     <= a_in * cos_in;
            bs_reg     <= b_in * sin_in;
            as_reg     <= a_in * sin_in;
            bc_reg     <= b_in * cos_in;
            pass_a_reg <= pass_in;
        end
    end

    assign diff = (PROD_W+1)'(ac_reg) - (PROD_W+1)'(bs_reg);
    assign sum  = (PROD_W+1)'(as_reg) + (PROD_W+1)'(bc_reg);

    always_ff @(posedge aclk) begin
        if (en_round) begin
            a_reg      <= vsrt_pkg::round_q16(64'(diff));
            b_reg      <= vsrt_pkg::round_q16(64'(sum));
            pass_b_reg <= pass_a_reg;
        end
    end

    assign a_out    = a_reg;
    assign b_out    = b_reg;
    assign pass_out = pass_b_reg;

endmodule

// ----- src/vertex_scale_rotate_translate.sv -----
// ----------------------------------------------------------------------------
// vertex_scale_rotate_translate
// Scales, rotates about x, y and z, then translates one vertex per word.
// ----------------------------------------------------------------------------
// Each input word carries a vertex position with its instance transform:
// per-axis scale, three Euler angles as fractions of a turn, and an offset.
// Each output word carries the transformed position, saturated Q16.16.
// Both channels use the usual valid/ready handshake; a word moves when
// tvalid and tready are high together at a rising edge of aclk.
// The pipeline is ten register stages deep, and one word can be taken every
// cycle unless the whole pipeline is full and its output is held off.
// The multipliers of the scale and of each rotation set the stage count.
// Every stage has its own valid bit and only stalls when the stage after
// it is full, so while the receiver holds off, empty stages keep filling
// and s_tready stays high until the whole pipeline is occupied.
// After reset the three sine tables are loaded, one entry per cycle, with
// SINE_TABLE_DEPTH + 1 entries (1025 by default); s_tready stays low
// during that load and the output channel is empty.
// ----------------------------------------------------------------------------
module vertex_scale_rotate_translate #(
    parameter int SINE_TABLE_DEPTH = vsrt_pkg::DEFAULT_SINE_TABLE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // in_x, in_y, in_z, scale_x, scale_y, scale_z, angle_x, angle_y,
    // angle_z, shift_x, shift_y, shift_z (from bit 0 up)
    input  logic [335:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_z (from bit 0 up)
    output logic [95:0]  m_tdata
);

    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int STAGES = 10;

    typedef logic [vsrt_pkg::TABLE_W-1:0] rom_t [0:SINE_TABLE_DEPTH];

    // Quarter-wave sine, Q1.16, from a Taylor series in Q2.30.
    function automatic rom_t build_rom();
        rom_t             r;
        longint unsigned  x;
        longint unsigned  x2;
        longint unsigned  term;
        longint unsigned  sum;
        longint unsigned  rounded;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = (longint'(k) * vsrt_pkg::HALF_PI_Q30) / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 10; n++) begin
                term = ((term * x2) >> 30) / vsrt_pkg::TAYLOR_DIV[n];
                if ((n % 2) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            rounded = (sum + 64'd8192) >> 14;
            r[k] = rounded[vsrt_pkg::TABLE_W-1:0];
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Table load after reset.
    logic              filling_reg;
    logic [ADDR_W-1:0] fill_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filling_reg  <= 1'b1;
            fill_cnt_reg <= '0;
        end else if (filling_reg) begin
            if (fill_cnt_reg == ADDR_W'(SINE_TABLE_DEPTH)) begin
                filling_reg <= 1'b0;
            end else begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
            end
        end
    end

    // Per-stage valid bits and stage enables: a stage may load when it is
    // empty or when the stage after it loads too.
    logic                valid_reg [1:STAGES];
    logic [STAGES+1:1]   en;

    always_comb begin
        en[STAGES+1] = m_tready;
        for (int k = STAGES; k >= 1; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[1] && !filling_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= STAGES; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else begin
            if (en[1]) begin
                valid_reg[1] <= s_tvalid && !filling_reg;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Input unpacking.
    vsrt_pkg::vec3_t  in_pos;
    vsrt_pkg::vec3_t  in_scale;
    vsrt_pkg::vec3_t  in_shift;
    vsrt_pkg::angle_t angle_x;
    vsrt_pkg::angle_t angle_y;
    vsrt_pkg::angle_t angle_z;

    assign in_pos.x   = s_tdata[31:0];
    assign in_pos.y   = s_tdata[63:32];
    assign in_pos.z   = s_tdata[95:64];
    assign in_scale.x = s_tdata[127:96];
    assign in_scale.y = s_tdata[159:128];
    assign in_scale.z = s_tdata[191:160];
    assign angle_x    = s_tdata[207:192];
    assign angle_y    = s_tdata[223:208];
    assign angle_z    = s_tdata[239:224];
    assign in_shift.x = s_tdata[271:240];
    assign in_shift.y = s_tdata[303:272];
    assign in_shift.z = s_tdata[335:304];

    // Stage 1: inputs registered, table reads in flight.
    vsrt_pkg::trig_val_t sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;

    vsrt_sincos #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_trig_x (
        .aclk(aclk), .en(en[1]), .fill_we(filling_reg), .fill_addr(fill_cnt_reg),
        .fill_data(SINE_ROM[fill_cnt_reg]), .angle(angle_x),
        .sin_val(sin_x), .cos_val(cos_x)
    );
    vsrt_sincos #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_trig_y (
        .aclk(aclk), .en(en[1]), .fill_we(filling_reg), .fill_addr(fill_cnt_reg),
        .fill_data(SINE_ROM[fill_cnt_reg]), .angle(angle_y),
        .sin_val(sin_y), .cos_val(cos_y)
    );
    vsrt_sincos #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_trig_z (
        .aclk(aclk), .en(en[1]), .fill_we(filling_reg), .fill_addr(fill_cnt_reg),
        .fill_data(SINE_ROM[fill_cnt_reg]), .angle(angle_z),
        .sin_val(sin_z), .cos_val(cos_z)
    );

    vsrt_pkg::vec3_t    pos1_reg;
    vsrt_pkg::vec3_t    scale1_reg;
    vsrt_pkg::vec3_t    shift_reg [1:9];
    logic signed [63:0] prod_x2_reg, prod_y2_reg, prod_z2_reg;
    vsrt_pkg::trig_t    trig_reg [2:7];
    vsrt_pkg::vec3_t    pos3_reg;
    vsrt_pkg::vec3_t    out_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            pos1_reg     <= in_pos;
            scale1_reg   <= in_scale;
            shift_reg[1] <= in_shift;
        end
        for (int k = 2; k <= 9; k++) begin
            if (en[k]) begin
                shift_reg[k] <= shift_reg[k-1];
            end
        end
        // Stage 2: scale products and signed sine and cosine.
        if (en[2]) begin
            prod_x2_reg <= pos1_reg.x * scale1_reg.x;
            prod_y2_reg <= pos1_reg.y * scale1_reg.y;
            prod_z2_reg <= pos1_reg.z * scale1_reg.z;
            trig_reg[2] <= '{sin_x, cos_x, sin_y, cos_y, sin_z, cos_z};
        end
        for (int k = 3; k <= 7; k++) begin
            if (en[k]) begin
                trig_reg[k] <= trig_reg[k-1];
            end
        end
        // Stage 3: scaled position rounded and clamped.
        if (en[3]) begin
            pos3_reg.x <= vsrt_pkg::round_q16(prod_x2_reg);
            pos3_reg.y <= vsrt_pkg::round_q16(prod_y2_reg);
            pos3_reg.z <= vsrt_pkg::round_q16(prod_z2_reg);
        end
    end

    // Stages 4 and 5: about x, turning y towards z.
    vsrt_pkg::coord_t x5, y5, z5;
    vsrt_rotate u_rot_x (
        .aclk(aclk), .en_prod(en[4]), .en_round(en[5]),
        .a_in(pos3_reg.y), .b_in(pos3_reg.z), .pass_in(pos3_reg.x),
        .cos_in(trig_reg[3].cos_x), .sin_in(trig_reg[3].sin_x),
        .a_out(y5), .b_out(z5), .pass_out(x5)
    );

    // Stages 6 and 7: about y, turning x towards z.
    vsrt_pkg::coord_t x7, y7, z7;
    vsrt_rotate u_rot_y (
        .aclk(aclk), .en_prod(en[6]), .en_round(en[7]),
        .a_in(x5), .b_in(z5), .pass_in(y5),
        .cos_in(trig_reg[5].cos_y), .sin_in(trig_reg[5].sin_y),
        .a_out(x7), .b_out(z7), .pass_out(y7)
    );

    // Stages 8 and 9: about z, turning x towards y.
    vsrt_pkg::coord_t x9, y9, z9;
    vsrt_rotate u_rot_z (
        .aclk(aclk), .en_prod(en[8]), .en_round(en[9]),
        .a_in(x7), .b_in(y7), .pass_in(z7),
        .cos_in(trig_reg[7].cos_z), .sin_in(trig_reg[7].sin_z),
        .a_out(x9), .b_out(y9), .pass_out(z9)
    );

    // Stage 10: translation with saturation, held until the word is taken.
    always_ff @(posedge aclk) begin
        if (en[10]) begin
            out_reg.x <= vsrt_pkg::sat32(64'(x9) + 64'(shift_reg[9].x));
            out_reg.y <= vsrt_pkg::sat32(64'(y9) + 64'(shift_reg[9].y));
            out_reg.z <= vsrt_pkg::sat32(64'(z9) + 64'(shift_reg[9].z));
        end
    end

    assign m_tvalid = valid_reg[STAGES];
    assign m_tdata  = {out_reg.z, out_reg.y, out_reg.x};

    // No words are taken while the sine tables are loading.
    assert property (@(posedge aclk) disable iff (!aresetn)
        filling_reg |-> !s_tready)
        else $error("input taken during table load");

    // Reset empties the output and starts the table load.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("pipeline not cleared by reset");

    // A full stage behind a stalled output keeps its word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[STAGES] && !m_tready && valid_reg[STAGES-1]
        |=> valid_reg[STAGES-1])
        else $error("word dropped behind stalled output");

    // Input can only be refused when every stage holds a word or the load runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready && !filling_reg |-> valid_reg[1] && valid_reg[STAGES] && !m_tready)
        else $error("input refused with room in pipeline");

endmodule

// ----- tb/vertex_scale_rotate_translate_test.sv -----
// ----------------------------------------------------------------------------
// vertex_scale_rotate_translate_test
// Self-checking bench for the scale, rotate and translate vertex pipeline.
// ----------------------------------------------------------------------------
// Every accepted input word is run through a predictor that builds its own
// quarter-wave sine table and works each stage out in 64-bit arithmetic. The
// predicted position is queued, and each output word is compared with the
// oldest prediction, field by field. Directed words cover the field extremes
// and the angle quadrant boundaries; random words follow, with random idling
// on both sides, one long receiver hold-off and one pause to drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vertex_scale_rotate_translate_test;

    localparam int DEPTH      = vsrt_pkg::DEFAULT_SINE_TABLE_DEPTH;
    localparam int LATENCY    = 10;
    localparam int CYCLE_CAP  = 400000;
    localparam int N_RANDOM   = 1830;

    // One input word, in the order of its fields from bit 0 up.
    typedef struct {
        vsrt_pkg::coord_t pos [3];
        vsrt_pkg::coord_t scl [3];
        vsrt_pkg::angle_t ang [3];
        vsrt_pkg::coord_t ofs [3];
    } vertex_job_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [335:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;

    // The sine table of the predictor, entry k holding sin(k/D * pi/2) in Q16.
    longint sine_lut [0:DEPTH];
    // Predicted positions, oldest first, each packed as out_x, out_y, out_z.
    logic [95:0] expected_positions [$];

    int  cycle_count = 0;
    int  error_count = 0;
    bit  sink_hold = 1'b0;     // set while the receiver is told to hold off
    bit  no_idle = 1'b0;       // set during the stretch with no idling

    vertex_scale_rotate_translate uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // A watchdog: the slowest run is far below this cap.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Taylor series in Q2.30, rounded to Q16 at the end.
    function automatic longint sine_entry(longint unsigned k);
        longint unsigned x, x2, term, sum;
        x = (k * 64'd1686629713) / DEPTH;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n & 1) sum = sum - term;
            else sum = sum + term;
        end
        return longint'((sum + 64'd8192) >> 14);
    endfunction

    function automatic longint sine_of(vsrt_pkg::angle_t a);
        longint unsigned idx;
        longint v;
        idx = (longint'(a[13:0]) * DEPTH) >> 14;
        if (idx > DEPTH) idx = DEPTH;
        v = a[14] ? sine_lut[DEPTH - idx] : sine_lut[idx];
        return a[15] ? -v : v;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Round half up from Q32.32 to Q16.16; >>> on a signed value is a floor.
    function automatic longint round_to_q16(longint p);
        return clamp_coord((p + 64'sd32768) >>> 16);
    endfunction

    function automatic void spin_pair(inout longint a, inout longint b,
                                      input vsrt_pkg::angle_t ang);
        longint c, s, a0, b0;
        c = sine_of(ang + 16'd16384);
        s = sine_of(ang);
        a0 = a;
        b0 = b;
        a = round_to_q16(a0 * c - b0 * s);
        b = round_to_q16(a0 * s + b0 * c);
    endfunction

    function automatic logic [95:0] transform_vertex(vertex_job_t j);
        longint p [3];
        for (int i = 0; i < 3; i++)
            p[i] = round_to_q16(longint'(j.pos[i]) * longint'(j.scl[i]));
        spin_pair(p[1], p[2], j.ang[0]);
        spin_pair(p[0], p[2], j.ang[1]);
        spin_pair(p[0], p[1], j.ang[2]);
        for (int i = 0; i < 3; i++)
            p[i] = clamp_coord(p[i] + longint'(j.ofs[i]));
        return {p[2][31:0], p[1][31:0], p[0][31:0]};
    endfunction

    function automatic logic [335:0] pack_job(vertex_job_t j);
        return {j.ofs[2], j.ofs[1], j.ofs[0], j.ang[2], j.ang[1], j.ang[0],
                j.scl[2], j.scl[1], j.scl[0], j.pos[2], j.pos[1], j.pos[0]};
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offers one word, with an occasional idle cycle before it, and waits
    // until it is taken. The prediction is queued at the accepting edge.
    task automatic send_vertex(vertex_job_t j);
        while (!no_idle && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_job(j);
        do @(posedge aclk); while (!s_tready);
        expected_positions.push_back(transform_vertex(j));
    endtask

    function automatic vsrt_pkg::coord_t pick_coord();
        case ($urandom_range(5))
            0: return vsrt_pkg::coord_t'(32'h7FFF_FFFF);
            1: return vsrt_pkg::coord_t'(32'h8000_0000);
            2: return vsrt_pkg::coord_t'($urandom_range(262144) - 131072);
            3: return vsrt_pkg::coord_t'($signed($urandom) >>> $urandom_range(31));
            default: return vsrt_pkg::coord_t'($urandom);
        endcase
    endfunction

    function automatic vertex_job_t random_job();
        vertex_job_t j;
        for (int i = 0; i < 3; i++) begin
            j.pos[i] = pick_coord();
            j.scl[i] = ($urandom_range(3) == 0) ? vsrt_pkg::coord_t'(32'h0001_0000)
                                                : pick_coord();
            j.ang[i] = ($urandom_range(3) == 0)
                       ? vsrt_pkg::angle_t'($urandom_range(7) * 8192)
                       : vsrt_pkg::angle_t'($urandom);
            j.ofs[i] = pick_coord();
        end
        return j;
    endfunction

    // Waits until every prediction has been matched, then lets the tail of
    // the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_positions.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, half-up rounding and every quadrant edge.
    task automatic test_directed();
        vertex_job_t j;
        vsrt_pkg::coord_t edge_vals [4] =
            '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
        vsrt_pkg::angle_t turn [8] = '{16'd0, 16'd16383, 16'd16384, 16'd32768,
                                       16'd49152, 16'd65535, 16'd8192, 16'd1};
        for (int k = 0; k < 8; k++) begin
            for (int i = 0; i < 3; i++) begin
                j.pos[i] = vsrt_pkg::coord_t'(32'h0001_8000 + i);
                j.scl[i] = vsrt_pkg::coord_t'(32'h0001_0000);
                j.ang[i] = turn[(k + i) % 8];
                j.ofs[i] = vsrt_pkg::coord_t'(0);
            end
            send_vertex(j);
        end
        for (int k = 0; k < 16; k++) begin
            for (int i = 0; i < 3; i++) begin
                j.pos[i] = edge_vals[(k + i) % 4];
                j.scl[i] = edge_vals[(k / 4 + i) % 4];
                j.ang[i] = (k & 1) ? 16'hFFFF : 16'h0000;
                j.ofs[i] = edge_vals[(k + 2 * i + 1) % 4];
            end
            send_vertex(j);
        end
        // A product landing exactly on one half rounds upwards.
        j.pos = '{32'sh0000_8000, -32'sh0000_8000, 32'sh0000_0001};
        j.scl = '{32'sh0000_0001, 32'sh0000_0001, 32'sh0000_8000};
        j.ang = '{16'd0, 16'd0, 16'd0};
        j.ofs = '{32'sh0, 32'sh0, 32'sh0};
        send_vertex(j);
        drain();
    endtask

    // Random words with random idling on both sides.
    task automatic test_random_stream(int count);
        for (int n = 0; n < count; n++) send_vertex(random_job());
    endtask

    // A stretch in which neither side idles at all.
    task automatic test_full_rate(int count);
        no_idle = 1'b1;
        test_random_stream(count);
        no_idle = 1'b0;
    endtask

    // The receiver holds off for a long stretch while words keep coming, so
    // the pipeline fills and stalls its input; then the sender pauses to
    // drain everything.
    task automatic test_back_pressure(int count);
        sink_hold = 1'b1;
        fork
            begin
                repeat (60) @(posedge aclk);
                sink_hold = 1'b0;
            end
            test_random_stream(count);
        join
        drain();
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !sink_hold && (no_idle || $urandom_range(99) >= 9);
        end
    end

    always @(posedge aclk) begin
        logic [95:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_positions.size() == 0) begin
                $error("output word with no prediction waiting: %h", m_tdata);
                error_count++;
            end else begin
                want = expected_positions.pop_front();
                for (int i = 0; i < 3; i++) begin
                    if (m_tdata[32*i +: 32] !== want[32*i +: 32]) begin
                        $error("out_%s expected %0d actual %0d",
                               (i == 0) ? "x" : (i == 1) ? "y" : "z",
                               $signed(want[32*i +: 32]), $signed(m_tdata[32*i +: 32]));
                        error_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        for (int k = 0; k <= DEPTH; k++) sine_lut[k] = sine_entry(k);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        // The block loads its sine tables before it takes the first word;
        // send_vertex simply waits on s_tready through that.
        test_directed();
        test_random_stream(N_RANDOM / 3);
        test_back_pressure(80);
        test_full_rate(400);
        test_random_stream(N_RANDOM - N_RANDOM / 3 - 480);
        drain();
        if (error_count == 0 && expected_positions.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
